[src/dedt_pkg.sv]
// Package for the diagnostic event debounce table: sizes, codes, beat types
// and the default fault code table. No dependencies.
package dedt_pkg;

  localparam int EVENTS = 32;
  localparam int IDX_W = (EVENTS > 1) ? $clog2(EVENTS) : 1;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int ST_FAILED = 0;
  localparam int ST_PENDING = 2;
  localparam int ST_CONFIRMED = 3;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    K_REPORT   = 3'd0,
    K_QUERY    = 3'd1,
    K_CLEAR    = 3'd2,
    K_SCAN     = 3'd3,
    K_SET_CODE = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_REPORT,
    OP_QUERY,
    OP_SET_CODE,
    OP_CLEAR,
    OP_SCAN,
    OP_RANGE_ERR,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    REG_ECU_SOURCE   = 2'd0,
    REG_BCAST_ENABLE = 2'd1,
    REG_FAIL_THR     = 2'd2,
    REG_PASS_THR     = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_EXEC,
    B_CLOSE
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  id;
    logic        failed;
    logic [23:0] code;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  event_index;
    logic        frame_valid;
    logic [23:0] fault_code;
    logic [7:0]  status_bits;
    logic [7:0]  source_id;
    logic [7:0]  occurrence_low;
    logic [31:0] occurrences;
    logic        error;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0]        ecu_source;
    logic              bcast_enable;
    logic [6:0]        fail_thr;
    logic signed [7:0] pass_thr;
  } cfg_t;

  // st[0] testFailed, st[1] pending, st[2] confirmed
  typedef struct packed {
    logic signed [7:0] cnt;
    logic [2:0]        st;
    logic [31:0]       occ;
    logic              sent;
  } ev_t;

  function automatic logic [7:0] status_byte(input logic [2:0] st);
    logic [7:0] b;
    b = '0;
    b[ST_FAILED] = st[0];
    b[ST_PENDING] = st[1];
    b[ST_CONFIRMED] = st[2];
    return b;
  endfunction

  function automatic logic [23:0] default_code(input logic [7:0] i);
    logic [23:0] c;
    case (i)
      8'd0:    c = 24'hC00100;
      8'd1:    c = 24'hC00200;
      8'd2:    c = 24'hC00300;
      8'd3:    c = 24'hC00400;
      8'd4:    c = 24'hC10100;
      8'd5:    c = 24'hC10200;
      8'd6:    c = 24'hC10300;
      8'd7:    c = 24'hC20100;
      8'd8:    c = 24'hC20200;
      8'd9:    c = 24'hC20300;
      8'd10:   c = 24'hC30100;
      8'd11:   c = 24'hC30200;
      8'd12:   c = 24'hC40100;
      8'd13:   c = 24'hC50100;
      8'd14:   c = 24'hC50200;
      8'd15:   c = 24'hC60100;
      8'd16:   c = 24'hC60200;
      8'd17:   c = 24'hC70100;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

[src/dedt_front.sv]
// Front end: accepts input beats, classifies them into commands and holds
// them in a two-entry command queue. Depends on dedt_pkg.
module dedt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [2:0]    kind_i,
  input  logic [7:0]    event_id_i,
  input  logic          failed_i,
  input  logic [23:0]   code_value_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output dedt_pkg::cmd_t cmd_o
);

  dedt_pkg::cmd_t cmd_in;
  dedt_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           in_range;
  logic           do_push, do_pop;

  always_comb begin
    in_range = {1'b0, event_id_i} < 9'(dedt_pkg::EVENTS);
    cmd_in.id = event_id_i;
    cmd_in.failed = failed_i;
    cmd_in.code = code_value_i;
    case (kind_i)
      dedt_pkg::K_REPORT:   cmd_in.op = in_range ? dedt_pkg::OP_REPORT : dedt_pkg::OP_RANGE_ERR;
      dedt_pkg::K_QUERY:    cmd_in.op = in_range ? dedt_pkg::OP_QUERY : dedt_pkg::OP_RANGE_ERR;
      dedt_pkg::K_SET_CODE: cmd_in.op = in_range ? dedt_pkg::OP_SET_CODE :
                                                   dedt_pkg::OP_RANGE_ERR;
      dedt_pkg::K_CLEAR:    cmd_in.op = dedt_pkg::OP_CLEAR;
      dedt_pkg::K_SCAN:     cmd_in.op = dedt_pkg::OP_SCAN;
      default:              cmd_in.op = dedt_pkg::OP_NOP;
    endcase
  end

  assign full_o = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[src/dedt_resq.sv]
// Result queue: two-entry queue of result beats between the back end and
// the result ports. Depends on dedt_pkg.
module dedt_resq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dedt_pkg::res_t res_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output dedt_pkg::res_t head_o
);

  dedt_pkg::res_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

[src/dedt_back.sv]
// Back end: sequencer over the event and code memories; does the
// read-modify-write of each command and walks the table for scans.
// Depends on dedt_pkg.
module dedt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dedt_pkg::cfg_t  cfg_i,
  input  logic            cmd_valid_i,
  input  dedt_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  input  logic            res_ready_i,
  output logic            res_push_o,
  output dedt_pkg::res_t  res_o
);

  dedt_pkg::back_state_e state_q, state_d;
  dedt_pkg::cmd_t        cur_q, cur_d;
  dedt_pkg::idx_t        scan_idx_q, scan_idx_d;
  logic [dedt_pkg::EVENTS-1:0] ev_valid_q, ev_valid_d;
  logic [dedt_pkg::EVENTS-1:0] code_set_q, code_set_d;

  dedt_pkg::ev_t ev_mem [dedt_pkg::EVENTS];
  logic [23:0]   code_mem [dedt_pkg::EVENTS];
  dedt_pkg::ev_t ev_rd_q;
  logic [23:0]   code_rd_q;

  dedt_pkg::idx_t    rd_idx;
  dedt_pkg::ev_t     ev_cur, ev_new, ev_rep;
  logic [23:0]       code_cur;
  logic              ev_we, code_we;
  logic signed [7:0] thr, cnt1;
  logic              eligible;
  logic              scan_last;

  assign rd_idx = (cur_q.op == dedt_pkg::OP_SCAN) ? scan_idx_q :
                  cur_q.id[dedt_pkg::IDX_W-1:0];
  assign ev_cur = ev_valid_q[rd_idx] ? ev_rd_q : '0;
  assign code_cur = code_set_q[rd_idx] ? code_rd_q : dedt_pkg::default_code(8'(rd_idx));
  assign thr = signed'({1'b0, cfg_i.fail_thr});
  assign scan_last = (scan_idx_q == dedt_pkg::IDX_W'(dedt_pkg::EVENTS - 1));
  assign eligible = ev_cur.st[2] && !ev_cur.sent && (code_cur != 24'd0);

  // debounce update for a report
  always_comb begin
    ev_rep = ev_cur;
    cnt1 = ev_cur.cnt;
    if (cur_q.failed) begin
      if (ev_cur.cnt < thr) begin
        cnt1 = ev_cur.cnt + 8'sd1;
      end
      ev_rep.st[0] = 1'b1;
      ev_rep.st[1] = 1'b1;
      if (cnt1 >= thr) begin
        ev_rep.st[2] = 1'b1;
        ev_rep.occ = ev_cur.occ + 32'd1;
      end
    end else begin
      if (ev_cur.cnt > cfg_i.pass_thr) begin
        cnt1 = ev_cur.cnt - 8'sd1;
      end
      if (cnt1 <= 8'sd0) begin
        ev_rep.st[0] = 1'b0;
      end
      if (cnt1 <= cfg_i.pass_thr) begin
        cnt1 = cfg_i.pass_thr;
      end
    end
    ev_rep.cnt = cnt1;
  end

  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    scan_idx_d = scan_idx_q;
    ev_valid_d = ev_valid_q;
    code_set_d = code_set_q;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o = '0;
    res_o.last = 1'b1;
    ev_we = 1'b0;
    code_we = 1'b0;
    ev_new = ev_rep;
    case (state_q)
      dedt_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d = cmd_i;
          scan_idx_d = '0;
          state_d = dedt_pkg::B_READ;
        end
      end
      dedt_pkg::B_READ: begin
        state_d = dedt_pkg::B_EXEC;
      end
      dedt_pkg::B_EXEC: begin
        if (cur_q.op == dedt_pkg::OP_SCAN) begin
          ev_new = ev_cur;
          ev_new.sent = 1'b1;
          res_o.event_index = 8'(scan_idx_q);
          res_o.frame_valid = 1'b1;
          res_o.fault_code = code_cur;
          res_o.status_bits = dedt_pkg::status_byte(ev_cur.st);
          res_o.source_id = cfg_i.ecu_source;
          res_o.occurrence_low = ev_cur.occ[7:0];
          res_o.last = 1'b0;
          if (!eligible || !cfg_i.bcast_enable || res_ready_i) begin
            ev_we = eligible;
            res_push_o = eligible && cfg_i.bcast_enable;
            if (scan_last) begin
              state_d = dedt_pkg::B_CLOSE;
            end else begin
              scan_idx_d = scan_idx_q + dedt_pkg::IDX_W'(1);
              state_d = dedt_pkg::B_READ;
            end
          end
        end else if (res_ready_i) begin
          res_push_o = 1'b1;
          state_d = dedt_pkg::B_IDLE;
          case (cur_q.op)
            dedt_pkg::OP_REPORT: begin
              ev_we = 1'b1;
              res_o.event_index = cur_q.id;
              res_o.status_bits = dedt_pkg::status_byte(ev_rep.st);
              res_o.occurrences = ev_rep.occ;
            end
            dedt_pkg::OP_QUERY: begin
              res_o.event_index = cur_q.id;
              res_o.status_bits = dedt_pkg::status_byte(ev_cur.st);
              res_o.occurrences = ev_cur.occ;
            end
            dedt_pkg::OP_SET_CODE: begin
              code_we = 1'b1;
              res_o.event_index = cur_q.id;
            end
            dedt_pkg::OP_CLEAR: begin
              ev_valid_d = '0;
            end
            dedt_pkg::OP_RANGE_ERR: begin
              res_o.event_index = cur_q.id;
              res_o.error = 1'b1;
            end
            default: begin
            end
          endcase
        end
        if (ev_we) begin
          ev_valid_d[rd_idx] = 1'b1;
        end
        if (code_we) begin
          code_set_d[rd_idx] = 1'b1;
        end
      end
      dedt_pkg::B_CLOSE: begin
        if (res_ready_i) begin
          res_push_o = 1'b1;
          state_d = dedt_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = dedt_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dedt_pkg::B_IDLE;
      ev_valid_q <= '0;
      code_set_q <= '0;
    end else begin
      state_q <= state_d;
      ev_valid_q <= ev_valid_d;
      code_set_q <= code_set_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    scan_idx_q <= scan_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dedt_pkg::B_READ) begin
      ev_rd_q <= ev_mem[rd_idx];
      code_rd_q <= code_mem[rd_idx];
    end
    if (ev_we) begin
      ev_mem[rd_idx] <= ev_new;
    end
    if (code_we) begin
      code_mem[rd_idx] <= cur_q.code;
    end
  end

`ifndef SYNTHESIS
  a_read_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dedt_pkg::B_READ) |=> (state_q == dedt_pkg::B_EXEC))
    else $error("read not followed by execute");

  a_range_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dedt_pkg::B_EXEC && cur_q.op == dedt_pkg::OP_RANGE_ERR) |->
    (!ev_we && !code_we))
    else $error("out-of-range command wrote a table");

  a_clear_drops_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dedt_pkg::B_EXEC && cur_q.op == dedt_pkg::OP_CLEAR && res_ready_i) |=>
    (ev_valid_q == '0))
    else $error("clear left a valid event");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> res_ready_i)
    else $error("result beat pushed into full queue");
`endif

endmodule

[src/diagnostic_event_debounce_table.sv]
// Top level of the diagnostic event debounce table: configuration registers,
// front end, back end and result queue. Depends on dedt_pkg, dedt_front,
// dedt_back and dedt_resq.
//
// Items enter through a two-entry command queue and results leave through a
// two-entry result queue. Each report, query, set-code, clear, out-of-range
// or unknown item passes through the back-end fetch, memory read and execute
// states, set by the single read port of the event memory and its
// read-modify-write; execute stalls while the result queue is full. A scan
// does one read and one execute per event plus the closing beat, and a full
// result queue can stall it. There is no clearing pass after reset.
module diagnostic_event_debounce_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [2:0]                    kind_i,
  input  logic [7:0]                    event_id_i,
  input  logic                          failed_i,
  input  logic [23:0]                   code_value_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    event_index_o,
  output logic                          frame_valid_o,
  output logic [23:0]                   fault_code_o,
  output logic [7:0]                    status_bits_o,
  output logic [7:0]                    source_id_o,
  output logic [7:0]                    occurrence_low_o,
  output logic [31:0]                   occurrences_o,
  output logic                          error_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dedt_pkg::ADDR_W-1:0]   paddr,
  input  logic [dedt_pkg::DATA_W-1:0]   pwdata,
  output logic [dedt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  dedt_pkg::cfg_t cfg_q;
  dedt_pkg::cmd_t cmd;
  dedt_pkg::res_t res_in, res_head;
  logic           cmd_valid, cmd_pop;
  logic           res_push, res_full;
  logic           cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ecu_source <= 8'd0;
      cfg_q.bcast_enable <= 1'b0;
      cfg_q.fail_thr <= 7'd3;
      cfg_q.pass_thr <= -8'sd3;
    end else if (cfg_we) begin
      case (paddr[dedt_pkg::ADDR_W-1:2])
        dedt_pkg::REG_ECU_SOURCE:   cfg_q.ecu_source <= pwdata[7:0];
        dedt_pkg::REG_BCAST_ENABLE: cfg_q.bcast_enable <= pwdata[0];
        dedt_pkg::REG_FAIL_THR:     cfg_q.fail_thr <= pwdata[6:0];
        dedt_pkg::REG_PASS_THR:     cfg_q.pass_thr <= signed'(pwdata[7:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[dedt_pkg::ADDR_W-1:2])
      dedt_pkg::REG_ECU_SOURCE:   prdata = dedt_pkg::DATA_W'(cfg_q.ecu_source);
      dedt_pkg::REG_BCAST_ENABLE: prdata = dedt_pkg::DATA_W'(cfg_q.bcast_enable);
      dedt_pkg::REG_FAIL_THR:     prdata = dedt_pkg::DATA_W'(cfg_q.fail_thr);
      dedt_pkg::REG_PASS_THR:     prdata = dedt_pkg::DATA_W'(unsigned'(cfg_q.pass_thr));
      default:                    prdata = '0;
    endcase
  end

  dedt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .kind_i       (kind_i),
    .event_id_i   (event_id_i),
    .failed_i     (failed_i),
    .code_value_i (code_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd)
  );

  dedt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (!res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  dedt_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (res_head)
  );

  assign event_index_o = res_head.event_index;
  assign frame_valid_o = res_head.frame_valid;
  assign fault_code_o = res_head.fault_code;
  assign status_bits_o = res_head.status_bits;
  assign source_id_o = res_head.source_id;
  assign occurrence_low_o = res_head.occurrence_low;
  assign occurrences_o = res_head.occurrences;
  assign error_o = res_head.error;
  assign last_o = res_head.last;

endmodule
